/* hdl/dcsa_pkg.sv */
// Shared types and constants for the dual channel sample averager.
package dcsa_pkg;

    localparam int SAMPLE_W = 8;
    localparam int AVG_W    = 8;
    localparam int CFG_W    = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic REG_MIN_GEAR_LEVEL = 1'b0;
    localparam logic REG_MAX_GEAR_JUMP  = 1'b1;

    localparam logic [CFG_W-1:0] MIN_GEAR_LEVEL_RST = 8'd16;
    localparam logic [CFG_W-1:0] MAX_GEAR_JUMP_RST  = 8'd32;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hdl/dcsa_div.sv */
// Restoring serial divider: window sum over fill count, one quotient bit per cycle.
module dcsa_div #(
    parameter int SUM_W  = 11,
    parameter int FILL_W = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [SUM_W-1:0]          dividend,
    input  logic [FILL_W-1:0]         divisor,
    output logic [dcsa_pkg::AVG_W-1:0] quotient,
    output dcsa_pkg::div_status_t     status
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [FILL_W-1:0]          rem_reg;
    logic [FILL_W-1:0]          rem_next;
    logic [SUM_W-1:0]           dvd_reg;
    logic [SUM_W-1:0]           dvd_next;
    logic [FILL_W-1:0]          dvs_reg;
    logic [FILL_W-1:0]          dvs_next;
    logic [dcsa_pkg::AVG_W-1:0] quot_reg;
    logic [dcsa_pkg::AVG_W-1:0] quot_next;
    logic [FILL_W:0]            trial;
    logic [FILL_W:0]            trial_sub;
    logic                       qbit;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign trial     = {rem_reg, dvd_reg[SUM_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign qbit      = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(SUM_W);
            busy_next = 1'b1;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? trial_sub[FILL_W-1:0] : trial[FILL_W-1:0];
            dvd_next  = {dvd_reg[SUM_W-2:0], 1'b0};
            // Only the low quotient bits survive; the true quotient fits them.
            quot_next = {quot_reg[dcsa_pkg::AVG_W-2:0], qbit};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign quotient    = (dvs_reg == '0) ? '0 : quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* hdl/dual_channel_sample_averager_core.sv */
// Dual channel moving average over battery and gear samples, rings kept in memories.
// A request passes S_CALC, S_START and S_WAIT, where the serial divider makes one
// quotient bit per cycle, then S_OUT, before the result is valid in the output register.
// A gear sample at or below the minimum level skips the divider and goes to S_OUT.
// Throughput: one request at a time; the next is accepted once the result is in the output
// register. Reset clears sums, fills, slots, valid bits and selects gear.
module dual_channel_sample_averager_core #(
    parameter int WINDOW_SIZE = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dcsa_pkg::SAMPLE_W-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                sample_channel,
    output logic                                gear_sample_used,
    output logic                                gear_window_restarted,
    output logic [dcsa_pkg::AVG_W-1:0]          battery_average,
    output logic [dcsa_pkg::AVG_W-1:0]          gear_average,
    output logic                                next_channel,
    output logic                                channel_switched,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dcsa_pkg::PADDR_W-1:0]        paddr,
    input  logic [dcsa_pkg::PDATA_W-1:0]        pwdata,
    output logic [dcsa_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int SLOT_W = $clog2(WINDOW_SIZE);
    localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = $clog2(WINDOW_SIZE * 255 + 1);
    localparam int SW     = dcsa_pkg::SAMPLE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SIZE - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_SIZE);

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;

    logic [SW-1:0]                batt_mem [WINDOW_SIZE];
    logic [SW-1:0]                gear_mem [WINDOW_SIZE];
    logic [SW-1:0]                batt_rd_reg;
    logic [SW-1:0]                gear_rd_reg;
    logic                         batt_we;
    logic                         gear_we;
    logic [SLOT_W-1:0]            gear_waddr;

    logic [WINDOW_SIZE-1:0]       batt_vld_reg;
    logic [WINDOW_SIZE-1:0]       batt_vld_next;
    logic [WINDOW_SIZE-1:0]       gear_vld_reg;
    logic [WINDOW_SIZE-1:0]       gear_vld_next;
    logic [SUM_W-1:0]             batt_sum_reg;
    logic [SUM_W-1:0]             batt_sum_next;
    logic [SUM_W-1:0]             gear_sum_reg;
    logic [SUM_W-1:0]             gear_sum_next;
    logic [SLOT_W-1:0]            batt_slot_reg;
    logic [SLOT_W-1:0]            batt_slot_next;
    logic [SLOT_W-1:0]            gear_slot_reg;
    logic [SLOT_W-1:0]            gear_slot_next;
    logic [FILL_W-1:0]            batt_fill_reg;
    logic [FILL_W-1:0]            batt_fill_next;
    logic [FILL_W-1:0]            gear_fill_reg;
    logic [FILL_W-1:0]            gear_fill_next;
    logic [SLOT_W-1:0]            grp_reg;
    logic [SLOT_W-1:0]            grp_next;
    logic                         sel_reg;
    logic                         sel_next;

    logic [dcsa_pkg::AVG_W-1:0]   batt_avg_reg;
    logic [dcsa_pkg::AVG_W-1:0]   batt_avg_next;
    logic [dcsa_pkg::AVG_W-1:0]   gear_avg_reg;
    logic [dcsa_pkg::AVG_W-1:0]   gear_avg_next;

    logic [SW-1:0]                sample_reg;
    logic                         chan_reg;
    logic                         chan_next;
    logic                         used_reg;
    logic                         used_next;
    logic                         restart_reg;
    logic                         restart_next;
    logic                         switch_reg;
    logic                         switch_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         o_chan_reg;
    logic                         o_used_reg;
    logic                         o_restart_reg;
    logic [dcsa_pkg::AVG_W-1:0]   o_batt_reg;
    logic [dcsa_pkg::AVG_W-1:0]   o_gear_reg;
    logic                         o_next_reg;
    logic                         o_switch_reg;
    logic                         out_load;

    logic [dcsa_pkg::CFG_W-1:0]   min_level_reg;
    logic [dcsa_pkg::CFG_W-1:0]   max_jump_reg;
    logic                         cfg_wr;

    logic                         in_acc;
    logic                         gear_pass;
    logic [SW-1:0]                gear_diff;
    logic                         gear_jump;
    logic [SW-1:0]                batt_old;
    logic [SW-1:0]                gear_old;

    logic                         div_start;
    logic [SUM_W-1:0]             div_dividend;
    logic [FILL_W-1:0]            div_divisor;
    logic [dcsa_pkg::AVG_W-1:0]   div_quot;
    dcsa_pkg::div_status_t        div_status;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg <= dcsa_pkg::MIN_GEAR_LEVEL_RST;
            max_jump_reg  <= dcsa_pkg::MAX_GEAR_JUMP_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                dcsa_pkg::REG_MIN_GEAR_LEVEL: min_level_reg <= pwdata[dcsa_pkg::CFG_W-1:0];
                dcsa_pkg::REG_MAX_GEAR_JUMP:  max_jump_reg  <= pwdata[dcsa_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            dcsa_pkg::REG_MIN_GEAR_LEVEL:
                prdata = {{(dcsa_pkg::PDATA_W - dcsa_pkg::CFG_W){1'b0}}, min_level_reg};
            dcsa_pkg::REG_MAX_GEAR_JUMP:
                prdata = {{(dcsa_pkg::PDATA_W - dcsa_pkg::CFG_W){1'b0}}, max_jump_reg};
            default:
                prdata = '0;
        endcase
    end

    // ---------------- ring memories ----------------
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (batt_we)
            batt_mem[batt_slot_reg] <= sample_reg;
        if (gear_we)
            gear_mem[gear_waddr] <= sample_reg;
        if (in_acc)
        begin
            batt_rd_reg <= batt_mem[batt_slot_reg];
            gear_rd_reg <= gear_mem[gear_slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            sample_reg <= sample;
    end

    // An entry never written since reset or restart reads as zero.
    assign batt_old = batt_vld_reg[batt_slot_reg] ? batt_rd_reg : '0;
    assign gear_old = gear_vld_reg[gear_slot_reg] ? gear_rd_reg : '0;

    assign gear_pass = (sample_reg > min_level_reg);
    assign gear_diff = (gear_avg_reg > sample_reg) ? (gear_avg_reg - sample_reg)
                                                   : (sample_reg - gear_avg_reg);
    assign gear_jump = (gear_diff > max_jump_reg);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        batt_vld_next  = batt_vld_reg;
        gear_vld_next  = gear_vld_reg;
        batt_sum_next  = batt_sum_reg;
        gear_sum_next  = gear_sum_reg;
        batt_slot_next = batt_slot_reg;
        gear_slot_next = gear_slot_reg;
        batt_fill_next = batt_fill_reg;
        gear_fill_next = gear_fill_reg;
        grp_next       = grp_reg;
        sel_next       = sel_reg;
        chan_next      = chan_reg;
        used_next      = used_reg;
        restart_next   = restart_reg;
        switch_next    = switch_reg;
        batt_avg_next  = batt_avg_reg;
        gear_avg_next  = gear_avg_reg;
        batt_we        = 1'b0;
        gear_we        = 1'b0;
        gear_waddr     = gear_slot_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = S_CALC;
            end
            S_CALC:
            begin
                chan_next    = sel_reg;
                used_next    = !sel_reg && gear_pass;
                restart_next = !sel_reg && gear_pass && gear_jump;
                if (sel_reg)
                begin
                    batt_we                       = 1'b1;
                    batt_sum_next                 = batt_sum_reg - SUM_W'(batt_old)
                                                    + SUM_W'(sample_reg);
                    batt_vld_next[batt_slot_reg]  = 1'b1;
                    batt_slot_next = (batt_slot_reg == SLOT_LAST) ? '0
                                     : batt_slot_reg + SLOT_W'(1);
                    batt_fill_next = (batt_fill_reg == FILL_FULL) ? batt_fill_reg
                                     : batt_fill_reg + FILL_W'(1);
                    state_next     = S_START;
                end
                else if (gear_pass)
                begin
                    gear_we = 1'b1;
                    if (gear_jump)
                    begin
                        // Restart the window: the sample becomes its first entry.
                        gear_waddr     = '0;
                        gear_vld_next  = '0;
                        gear_vld_next[0] = 1'b1;
                        gear_sum_next  = SUM_W'(sample_reg);
                        gear_slot_next = SLOT_W'(1);
                        gear_fill_next = FILL_W'(1);
                    end
                    else
                    begin
                        gear_sum_next  = gear_sum_reg - SUM_W'(gear_old)
                                         + SUM_W'(sample_reg);
                        gear_vld_next[gear_slot_reg] = 1'b1;
                        gear_slot_next = (gear_slot_reg == SLOT_LAST) ? '0
                                         : gear_slot_reg + SLOT_W'(1);
                        gear_fill_next = (gear_fill_reg == FILL_FULL) ? gear_fill_reg
                                         : gear_fill_reg + FILL_W'(1);
                    end
                    state_next = S_START;
                end
                else
                begin
                    state_next = S_OUT;
                end
                if (grp_reg == SLOT_LAST)
                begin
                    grp_next    = '0;
                    sel_next    = !sel_reg;
                    switch_next = 1'b1;
                end
                else
                begin
                    grp_next    = grp_reg + SLOT_W'(1);
                    switch_next = 1'b0;
                end
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_status.done)
                begin
                    if (chan_reg)
                        batt_avg_next = (batt_fill_reg == '0) ? '0 : div_quot;
                    else
                        gear_avg_next = (gear_fill_reg == '0) ? '0 : div_quot;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign div_dividend = chan_reg ? batt_sum_reg : gear_sum_reg;
    assign div_divisor  = chan_reg ? batt_fill_reg : gear_fill_reg;

    dcsa_div #(
        .SUM_W  (SUM_W),
        .FILL_W (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            batt_vld_reg  <= '0;
            gear_vld_reg  <= '0;
            batt_sum_reg  <= '0;
            gear_sum_reg  <= '0;
            batt_slot_reg <= '0;
            gear_slot_reg <= '0;
            batt_fill_reg <= '0;
            gear_fill_reg <= '0;
            grp_reg       <= '0;
            sel_reg       <= 1'b0;
            batt_avg_reg  <= '0;
            gear_avg_reg  <= '0;
            chan_reg      <= 1'b0;
            used_reg      <= 1'b0;
            restart_reg   <= 1'b0;
            switch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            batt_vld_reg  <= batt_vld_next;
            gear_vld_reg  <= gear_vld_next;
            batt_sum_reg  <= batt_sum_next;
            gear_sum_reg  <= gear_sum_next;
            batt_slot_reg <= batt_slot_next;
            gear_slot_reg <= gear_slot_next;
            batt_fill_reg <= batt_fill_next;
            gear_fill_reg <= gear_fill_next;
            grp_reg       <= grp_next;
            sel_reg       <= sel_next;
            batt_avg_reg  <= batt_avg_next;
            gear_avg_reg  <= gear_avg_next;
            chan_reg      <= chan_next;
            used_reg      <= used_next;
            restart_reg   <= restart_next;
            switch_reg    <= switch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_chan_reg    <= chan_reg;
            o_used_reg    <= used_reg;
            o_restart_reg <= restart_reg;
            o_batt_reg    <= batt_avg_reg;
            o_gear_reg    <= gear_avg_reg;
            o_next_reg    <= sel_reg;
            o_switch_reg  <= switch_reg;
        end
    end

    assign out_valid             = out_valid_reg;
    assign sample_channel        = o_chan_reg;
    assign gear_sample_used      = o_used_reg;
    assign gear_window_restarted = o_restart_reg;
    assign battery_average       = o_batt_reg;
    assign gear_average          = o_gear_reg;
    assign next_channel          = o_next_reg;
    assign channel_switched      = o_switch_reg;

`ifndef SYNTH
    a_accept_locks: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall && (state_reg == S_CALC))
        else $error("request accepted but sequencer did not start");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (batt_fill_reg <= FILL_FULL) && (gear_fill_reg <= FILL_FULL))
        else $error("window fill count beyond window size");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_WAIT))
        else $error("divider finished outside the wait state");

    a_restart_gear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gear_window_restarted |-> gear_sample_used && !sample_channel)
        else $error("window restart reported without a used gear sample");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the dual channel sample averager core.
module tb_top;

    localparam int WIN             = 8;
    localparam int GAP_MAX         = 12;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int NUM_PHASES      = 8;
    localparam int DRAIN_CYCLES    = 24;
    localparam int IDLE_LIMIT      = 3000;

    typedef enum logic {
        CH_GEAR    = 1'b0,
        CH_BATTERY = 1'b1
    } channel_e;

    typedef struct packed {
        logic                       sample_channel;
        logic                       gear_used;
        logic                       restarted;
        logic [dcsa_pkg::AVG_W-1:0] battery_avg;
        logic [dcsa_pkg::AVG_W-1:0] gear_avg;
        logic                       next_channel;
        logic                       switched;
    } avg_result_t;

    class avg_scoreboard;
        logic [dcsa_pkg::SAMPLE_W-1:0] ring [2][WIN];
        int unsigned                   total [2];
        int unsigned                   slot [2];
        int unsigned                   fill [2];
        int unsigned                   group_count;
        channel_e                      channel;
        logic [dcsa_pkg::CFG_W-1:0]    min_level;
        logic [dcsa_pkg::CFG_W-1:0]    max_jump;
        avg_result_t                   pending_results [$];
        int                            errors;

        function new();
            foreach (ring[c, i]) ring[c][i] = '0;
            clear_window(CH_GEAR);
            clear_window(CH_BATTERY);
            group_count = 0;
            channel     = CH_GEAR;
            min_level   = dcsa_pkg::MIN_GEAR_LEVEL_RST;
            max_jump    = dcsa_pkg::MAX_GEAR_JUMP_RST;
            errors      = 0;
        endfunction

        function void clear_window(channel_e ch);
            for (int i = 0; i < WIN; i++) ring[ch][i] = '0;
            total[ch] = 0;
            slot[ch]  = 0;
            fill[ch]  = 0;
        endfunction

        function logic [dcsa_pkg::AVG_W-1:0] average(channel_e ch);
            if (fill[ch] == 0)
            begin
                return '0;
            end
            return dcsa_pkg::AVG_W'(total[ch] / fill[ch]);
        endfunction

        function void push(channel_e ch, logic [dcsa_pkg::SAMPLE_W-1:0] value);
            int unsigned s;
            s         = slot[ch];
            // the overwritten entry is zero until the window has filled
            total[ch] = total[ch] - ring[ch][s] + value;
            ring[ch][s] = value;
            slot[ch]  = (s + 1) % WIN;
            if (fill[ch] < WIN)
            begin
                fill[ch]++;
            end
        endfunction

        function void set_config(logic index, logic [dcsa_pkg::CFG_W-1:0] value);
            if (index == dcsa_pkg::REG_MIN_GEAR_LEVEL)
            begin
                min_level = value;
            end
            else
            begin
                max_jump = value;
            end
        endfunction

        function void note_request(logic [dcsa_pkg::SAMPLE_W-1:0] value);
            avg_result_t r;
            int unsigned avg;
            int unsigned diff;
            r                = '0;
            r.sample_channel = channel;
            group_count++;
            if (channel == CH_BATTERY)
            begin
                push(CH_BATTERY, value);
            end
            else if (value > min_level)
            begin
                avg         = average(CH_GEAR);
                diff        = (avg > value) ? avg - value : value - avg;
                r.gear_used = 1'b1;
                if (diff > max_jump)
                begin
                    clear_window(CH_GEAR);
                    r.restarted = 1'b1;
                end
                push(CH_GEAR, value);
            end
            if (group_count >= WIN)
            begin
                group_count = 0;
                channel     = (channel == CH_GEAR) ? CH_BATTERY : CH_GEAR;
                r.switched  = 1'b1;
            end
            r.battery_avg  = average(CH_BATTERY);
            r.gear_avg     = average(CH_GEAR);
            r.next_channel = channel;
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] ERROR: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("%s: got %0d, expected %0d", name, got, want));
            end
        endtask

        task check_result(avg_result_t got);
            avg_result_t want;
            if (pending_results.size() == 0)
            begin
                report("result arrived with no request pending");
                return;
            end
            want = pending_results.pop_front();
            compare_field("sample_channel", got.sample_channel, want.sample_channel);
            compare_field("gear_sample_used", got.gear_used, want.gear_used);
            compare_field("gear_window_restarted", got.restarted, want.restarted);
            compare_field("battery_average", got.battery_avg, want.battery_avg);
            compare_field("gear_average", got.gear_avg, want.gear_avg);
            compare_field("next_channel", got.next_channel, want.next_channel);
            compare_field("channel_switched", got.switched, want.switched);
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [dcsa_pkg::SAMPLE_W-1:0] sample;
    logic                          out_valid;
    logic                          out_stall;
    logic                          sample_channel;
    logic                          gear_sample_used;
    logic                          gear_window_restarted;
    logic [dcsa_pkg::AVG_W-1:0]    battery_average;
    logic [dcsa_pkg::AVG_W-1:0]    gear_average;
    logic                          next_channel;
    logic                          channel_switched;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [dcsa_pkg::PADDR_W-1:0]  paddr;
    logic [dcsa_pkg::PDATA_W-1:0]  pwdata;
    logic [dcsa_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    avg_scoreboard sb = new();

    bit in_calm;
    bit out_calm;
    int idle_cycles;
    int last_sample;

    logic [dcsa_pkg::SAMPLE_W-1:0] directed_seq [25] = '{
        // gear group: below, at and just above the minimum level, jump limits
        8'd0, 8'd16, 8'd17, 8'd49, 8'd83, 8'd255, 8'd0, 8'd254,
        // battery group: full scale and zero
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
        // gear group again, then one battery sample to wrap the ring
        8'd17, 8'd255, 8'd223, 8'd1, 8'd128, 8'd160, 8'd161, 8'd200,
        8'd255
    };

    dual_channel_sample_averager_core #(
        .WINDOW_SIZE(WIN)
    ) dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : monitor
        avg_result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_request(sample);
            end
            if (out_valid && !out_stall)
            begin
                got.sample_channel = sample_channel;
                got.gear_used      = gear_sample_used;
                got.restarted      = gear_window_restarted;
                got.battery_avg    = battery_average;
                got.gear_avg       = gear_average;
                got.next_channel   = next_channel;
                got.switched       = channel_switched;
                sb.check_result(got);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable && pready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : result_sink
        int n;
        out_stall = 1'b0;
        forever
        begin
            n = out_calm ? 0 : $urandom_range(0, GAP_MAX);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task send_request(logic [dcsa_pkg::SAMPLE_W-1:0] value);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task write_register(logic index, logic [dcsa_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dcsa_pkg::PADDR_W'({index, 2'b00});
        pwdata  <= dcsa_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        sb.set_config(index, value);
    endtask

    task check_register(logic index, logic [dcsa_pkg::CFG_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= dcsa_pkg::PADDR_W'({index, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[dcsa_pkg::CFG_W-1:0] != want)
        begin
            sb.report($sformatf("register %0d read %0d, expected %0d",
                                index, prdata[dcsa_pkg::CFG_W-1:0], want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task wait_drained();
        // let the monitor note the last accepted request first
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Bias samples toward the gear average, the jump limit and the minimum level.
    function logic [dcsa_pkg::SAMPLE_W-1:0] pick_sample();
        int r;
        int base;
        int off;
        int v;
        r    = $urandom_range(0, 99);
        base = int'(sb.average(CH_GEAR));
        if (r < 35)
        begin
            v = $urandom_range(0, 255);
        end
        else if (r < 65)
        begin
            off = $urandom_range(0, int'(sb.max_jump) + 2);
            v   = $urandom_range(0, 1) ? base + off : base - off;
        end
        else if (r < 80)
        begin
            v = int'(sb.min_level) + int'($urandom_range(0, 2)) - 1;
        end
        else if (r < 90)
        begin
            v = $urandom_range(0, 1) ? 255 : 0;
        end
        else
        begin
            v = last_sample + int'($urandom_range(0, 6)) - 3;
        end
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 255)
        begin
            v = 255;
        end
        last_sample = v;
        return dcsa_pkg::SAMPLE_W'(v);
    endfunction

    task run_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                in_calm  = ($urandom_range(0, 3) == 0);
                out_calm = ($urandom_range(0, 3) == 0);
            end
            send_request(pick_sample());
        end
        in_valid <= 1'b0;
    endtask

    task apply_phase_config(int phase);
        logic [dcsa_pkg::CFG_W-1:0] min_cfg;
        logic [dcsa_pkg::CFG_W-1:0] jump_cfg;
        case (phase)
            1:
            begin
                min_cfg  = 8'd0;
                jump_cfg = 8'd0;
            end
            2:
            begin
                min_cfg  = 8'd255;
                jump_cfg = 8'd255;
            end
            3:
            begin
                min_cfg  = 8'd0;
                jump_cfg = 8'd255;
            end
            4:
            begin
                min_cfg  = 8'd255;
                jump_cfg = 8'd0;
            end
            5:
            begin
                min_cfg  = dcsa_pkg::MIN_GEAR_LEVEL_RST;
                jump_cfg = dcsa_pkg::MAX_GEAR_JUMP_RST;
            end
            default:
            begin
                min_cfg  = dcsa_pkg::CFG_W'($urandom_range(0, 60));
                jump_cfg = dcsa_pkg::CFG_W'($urandom_range(0, 80));
            end
        endcase
        write_register(dcsa_pkg::REG_MIN_GEAR_LEVEL, min_cfg);
        write_register(dcsa_pkg::REG_MAX_GEAR_JUMP, jump_cfg);
        check_register(dcsa_pkg::REG_MIN_GEAR_LEVEL, min_cfg);
        check_register(dcsa_pkg::REG_MAX_GEAR_JUMP, jump_cfg);
    endtask

    initial
    begin : stimulus
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_calm     = 1'b0;
        out_calm    = 1'b0;
        last_sample = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_register(dcsa_pkg::REG_MIN_GEAR_LEVEL, dcsa_pkg::MIN_GEAR_LEVEL_RST);
        check_register(dcsa_pkg::REG_MAX_GEAR_JUMP, dcsa_pkg::MAX_GEAR_JUMP_RST);

        foreach (directed_seq[i])
        begin
            send_request(directed_seq[i]);
        end
        in_valid <= 1'b0;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // phase 0 keeps the reset configuration
            if (phase != 0)
            begin
                wait_drained();
                apply_phase_config(phase);
            end
            run_random(ITEMS_PER_PHASE);
        end

        wait_drained();
        if (sb.pending_results.size() != 0)
        begin
            sb.report("requests left without a result");
        end
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
